### rtl/dne_pkg.sv
// Shared types and constants of the delta nibble encoder.
package dne_pkg;

    // Stream mode, one-hot
    typedef enum logic [2:0] {
        MODE_WORD = 3'b001,
        MODE_BYTE = 3'b010,
        MODE_NIB  = 3'b100
    } t_mode;

    // Escape codes of the packed stream
    localparam logic [15:0] ESC_ENTER_BYTE = 16'h8000;
    localparam logic [7:0]  ESC_ENTER_NIB  = 8'h80;
    localparam logic [7:0]  ESC_TO_WORD    = 8'h81;
    localparam logic [3:0]  ESC_LEAVE_NIB  = 4'h8;

    // Most negative sample and the value it saturates to
    localparam logic [15:0] SAMPLE_MIN = 16'h8000;
    localparam logic [15:0] SAMPLE_SAT = 16'h8001;

    localparam int unsigned MAX_NIBS = 7;

    // Coder state carried from one sample to the next
    typedef struct packed {
        t_mode              mode;
        logic signed [15:0] prev_sample;
        logic signed [16:0] prev_diff;
    } t_state;

    localparam t_state STATE_RESET = '{mode: MODE_WORD, prev_sample: '0, prev_diff: '0};

    // All nibbles caused by one sample, in stream order
    typedef struct packed {
        logic [MAX_NIBS-1:0][3:0] nib;
        logic [2:0]               cnt;
    } t_frame;

endpackage

### rtl/delta_nibble_encoder_top.sv
// Top level of the adaptive delta / delta-delta nibble encoder.
//
// Usage:
//   Slave channel s_axis takes one word per sample: tdata carries the signed
//   16-bit sample, tuser the restart flag (word mode, history cleared before
//   this sample is coded).
//   Master channel m_axis gives the packed code stream, one nibble per word in
//   tdata[3:0]; tlast marks the final nibble caused by each sample.
//   Each sample causes 1 to 7 nibbles. The first nibble is presented once the
//   sample has passed the input register and then the frame buffer. The output
//   side runs at one nibble per cycle while m_axis_tready stays high; a frame
//   holds from 1 nibble (nibble mode, small second difference) up to 7 (mode
//   escapes plus raw word). The input register takes the next sample while the
//   frame buffer still drains, and the frame of a sample held there follows the
//   last nibble without a gap.
//   A receiver stall holds the current nibble; once the input register is
//   also full, s_axis_tready drops until the frame drains.
//   Reset (synchronous, active low) empties both registers and returns the
//   coder to word mode with zero history.
module delta_nibble_encoder_top
    import dne_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample
    input  logic        s_axis_tuser,   // [0] first
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [3:0] nibble, [7:4] zero
    output logic        m_axis_tlast
);

    logic        r_in_vld;
    logic [15:0] r_in_sample;
    logic        r_in_first;
    logic        r_buf_vld;
    t_frame      r_buf;
    logic [2:0]  r_idx;
    t_state      r_state;

    t_frame      n_frame;
    t_state      n_state;
    logic        load;
    logic        out_fire;
    logic        buf_last;

    dne_encode u_encode (
        .i_sample (r_in_sample),
        .i_first  (r_in_first),
        .i_state  (r_state),
        .o_frame  (n_frame),
        .o_state  (n_state)
    );

    // Handshake and frame hand-over
    assign buf_last      = (r_idx == (r_buf.cnt - 3'd1));
    assign out_fire      = r_buf_vld && m_axis_tready;
    assign load          = r_in_vld && (!r_buf_vld || (out_fire && buf_last));
    assign s_axis_tready = !r_in_vld || load;

    assign m_axis_tvalid = r_buf_vld;
    assign m_axis_tdata  = {4'h0, r_buf.nib[r_idx]};
    assign m_axis_tlast  = buf_last;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_vld <= 1'b1;
        end else if (load) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_sample <= s_axis_tdata;
            r_in_first  <= s_axis_tuser;
        end
    end

    // Frame buffer: load a coded frame, advance one nibble per word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_vld <= 1'b0;
            r_idx     <= '0;
        end else if (load) begin
            r_buf_vld <= 1'b1;
            r_idx     <= '0;
        end else if (out_fire) begin
            if (buf_last) begin
                r_buf_vld <= 1'b0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_buf <= n_frame;
        end
    end

    // Coder state advances as each sample is coded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (load) begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/dne_encode.sv
// Combinational coder: one sample and the coder state to a nibble frame and next state.
module dne_encode
    import dne_pkg::*;
(
    input  logic [15:0] i_sample,
    input  logic        i_first,
    input  t_state      i_state,
    output t_frame      o_frame,
    output t_state      o_state
);

    logic signed [15:0] s;
    logic signed [16:0] d;
    logic signed [17:0] d2;
    t_state             cur;
    logic               byte_ok;
    logic               nib_ok;
    logic [7:0]         db;
    logic [3:0]         dn;

    always_comb begin
        // Saturate the escape value and apply restart
        s   = (i_sample == SAMPLE_MIN) ? SAMPLE_SAT : i_sample;
        cur = i_first ? STATE_RESET : i_state;

        // First and second differences
        d       = {s[15], s} - {cur.prev_sample[15], cur.prev_sample};
        d2      = {d[16], d} - {cur.prev_diff[16], cur.prev_diff};
        byte_ok = (d <= 17'sd127) && (d >= -17'sd126);
        nib_ok  = (d2 <= 18'sd7) && (d2 >= -18'sd7);
        db      = d[7:0];
        dn      = d2[3:0];

        o_frame       = '0;
        o_state.mode  = MODE_WORD;
        o_state.prev_sample = s;
        o_state.prev_diff   = d;

        case (cur.mode)
            MODE_BYTE: begin
                if (!byte_ok) begin
                    // back to word mode with the raw sample
                    o_frame.nib[0] = ESC_TO_WORD[7:4];
                    o_frame.nib[1] = ESC_TO_WORD[3:0];
                    o_frame.nib[2] = s[7:4];
                    o_frame.nib[3] = s[3:0];
                    o_frame.nib[4] = s[15:12];
                    o_frame.nib[5] = s[11:8];
                    o_frame.cnt    = 3'd6;
                    o_state.mode   = MODE_WORD;
                end else if (nib_ok) begin
                    o_frame.nib[0] = ESC_ENTER_NIB[7:4];
                    o_frame.nib[1] = ESC_ENTER_NIB[3:0];
                    o_frame.nib[2] = dn;
                    o_frame.cnt    = 3'd3;
                    o_state.mode   = MODE_NIB;
                end else begin
                    o_frame.nib[0] = db[7:4];
                    o_frame.nib[1] = db[3:0];
                    o_frame.cnt    = 3'd2;
                    o_state.mode   = MODE_BYTE;
                end
            end
            MODE_NIB: begin
                if (nib_ok) begin
                    o_frame.nib[0] = dn;
                    o_frame.cnt    = 3'd1;
                    o_state.mode   = MODE_NIB;
                end else if (byte_ok) begin
                    // leave nibble mode, then a byte difference
                    o_frame.nib[0] = ESC_LEAVE_NIB;
                    o_frame.nib[1] = db[7:4];
                    o_frame.nib[2] = db[3:0];
                    o_frame.cnt    = 3'd3;
                    o_state.mode   = MODE_BYTE;
                end else begin
                    o_frame.nib[0] = ESC_LEAVE_NIB;
                    o_frame.nib[1] = ESC_TO_WORD[7:4];
                    o_frame.nib[2] = ESC_TO_WORD[3:0];
                    o_frame.nib[3] = s[7:4];
                    o_frame.nib[4] = s[3:0];
                    o_frame.nib[5] = s[15:12];
                    o_frame.nib[6] = s[11:8];
                    o_frame.cnt    = 3'd7;
                    o_state.mode   = MODE_WORD;
                end
            end
            default: begin
                // word mode
                if (byte_ok) begin
                    o_frame.nib[0] = ESC_ENTER_BYTE[7:4];
                    o_frame.nib[1] = ESC_ENTER_BYTE[3:0];
                    o_frame.nib[2] = ESC_ENTER_BYTE[15:12];
                    o_frame.nib[3] = ESC_ENTER_BYTE[11:8];
                    o_frame.nib[4] = db[7:4];
                    o_frame.nib[5] = db[3:0];
                    o_frame.cnt    = 3'd6;
                    o_state.mode   = MODE_BYTE;
                end else begin
                    o_frame.nib[0] = s[7:4];
                    o_frame.nib[1] = s[3:0];
                    o_frame.nib[2] = s[15:12];
                    o_frame.nib[3] = s[11:8];
                    o_frame.cnt    = 3'd4;
                    o_state.mode   = MODE_WORD;
                end
            end
        endcase
    end

endmodule

### rtl/dne_checker.sv
// Port-level checker for the delta nibble encoder, bound to the top level.
module dne_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    // Stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output word changed under stall");

    // Nibbles of one frame follow without a gap
    a_frame_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("gap inside a frame");

    // Input only backs up behind a pending frame
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no frame pending");

    // Reset leaves both sides empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("not empty after reset");

    // Padding bits stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:4] == 4'h0))
        else $error("nonzero padding");

endmodule

bind delta_nibble_encoder_top dne_checker u_dne_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

### verif/tb_delta_nibble_encoder_top.sv
// Self-checking testbench of the delta nibble encoder top level.
`timescale 1ns / 1ps

module tb_delta_nibble_encoder_top
    import dne_pkg::*;
();

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 3;
    localparam int RANDOM_ITEMS = 460;
    localparam int DRAIN_CYCLES = 16;
    localparam int LONG_HOLD    = 300;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int N_DIRECTED   = 25;

    // One expected nibble of the code stream
    typedef struct packed {
        logic [3:0] nib;
        logic       last;
    } t_coded_nibble;

    // Predicts the nibble stream and checks what the block sends
    class nibble_coder_model;
        t_mode         mode;
        int            held_sample;
        int            held_diff;
        logic [3:0]    frame[$];
        t_coded_nibble pending_nibbles[$];
        int            mismatches;

        function new();
            restart();
            mismatches = 0;
        endfunction

        function void restart();
            mode        = MODE_WORD;
            held_sample = 0;
            held_diff   = 0;
        endfunction

        function void push_nib(logic [3:0] v);
            frame.push_back(v);
        endfunction

        function void push_byte(logic [7:0] b);
            push_nib(b[7:4]);
            push_nib(b[3:0]);
        endfunction

        // Low byte first, each byte high nibble first
        function void push_word(logic [15:0] w);
            push_byte(w[7:0]);
            push_byte(w[15:8]);
        endfunction

        // Code one accepted sample and queue the nibbles it causes
        function void code_sample(logic [15:0] raw, logic first);
            int s;
            int d;
            int d2;
            bit fits_byte;
            bit fits_nib;
            s = $signed(raw);
            if (raw == SAMPLE_MIN) begin
                s = $signed(SAMPLE_SAT);
            end
            if (first) begin
                restart();
            end
            d  = s - held_sample;
            d2 = d - held_diff;
            // -127 is kept out of byte mode: its byte would read as the word escape
            fits_byte = (d <= 127) && (d >= -126);
            fits_nib  = (d2 <= 7) && (d2 >= -7);
            frame.delete();
            case (mode)
                MODE_BYTE: begin
                    if (!fits_byte) begin
                        push_byte(ESC_TO_WORD);
                        push_word(s[15:0]);
                        mode = MODE_WORD;
                    end else if (fits_nib) begin
                        push_byte(ESC_ENTER_NIB);
                        push_nib(d2[3:0]);
                        mode = MODE_NIB;
                    end else begin
                        push_byte(d[7:0]);
                    end
                end
                MODE_NIB: begin
                    if (fits_nib) begin
                        push_nib(d2[3:0]);
                    end else begin
                        push_nib(ESC_LEAVE_NIB);
                        if (fits_byte) begin
                            push_byte(d[7:0]);
                            mode = MODE_BYTE;
                        end else begin
                            push_byte(ESC_TO_WORD);
                            push_word(s[15:0]);
                            mode = MODE_WORD;
                        end
                    end
                end
                default: begin
                    if (fits_byte) begin
                        push_word(ESC_ENTER_BYTE);
                        push_byte(d[7:0]);
                        mode = MODE_BYTE;
                    end else begin
                        push_word(s[15:0]);
                        mode = MODE_WORD;
                    end
                end
            endcase
            held_diff   = d;
            held_sample = s;
            foreach (frame[i]) begin
                pending_nibbles.push_back('{nib: frame[i], last: (i == frame.size() - 1)});
            end
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        // Compare one accepted output word with the oldest expectation
        task check_nibble(logic [7:0] data, logic last);
            t_coded_nibble want;
            if (pending_nibbles.size() == 0) begin
                report($sformatf("unexpected word data=%h last=%b", data, last));
            end else begin
                want = pending_nibbles.pop_front();
                if (data[3:0] !== want.nib) begin
                    report($sformatf("nibble %h, want %h", data[3:0], want.nib));
                end
                if (data[7:4] !== 4'h0) begin
                    report($sformatf("padding bits %h not zero", data[7:4]));
                end
                if (last !== want.last) begin
                    report($sformatf("last %b, want %b", last, want.last));
                end
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [15:0] sample
    logic        s_axis_tuser;   // [0] first
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [3:0] nibble, [7:4] zero
    logic        m_axis_tlast;

    nibble_coder_model coder = new();

    bit idle_on     = 1'b1;
    int rx_hold_len = 0;
    int burst_free  = 0;
    int cycle_count = 0;

    delta_nibble_encoder_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Abort a run that hangs
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    // Note accepted samples and check accepted words at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                coder.code_sample(s_axis_tdata, s_axis_tuser);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                coder.check_nibble(m_axis_tdata, m_axis_tlast);
            end
        end
    end

    // Receiver: random stall bursts, one long hold on request
    initial begin
        int n;
        m_axis_tready = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (rx_hold_len > 0) begin
                m_axis_tready <= 1'b0;
                n = rx_hold_len;
                rx_hold_len = 0;
                repeat (n) @(negedge i_clk);
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(negedge i_clk);
            end
        end
    end

    // Offer one sample, after an optional gap, and hold it until accepted
    task send_sample(logic [15:0] sample, logic first);
        int gap;
        gap = 0;
        if (burst_free > 0) begin
            burst_free--;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 17);
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sample;
        s_axis_tuser  <= first;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // Stop offering and wait until every expected nibble has arrived
    task wait_for_drain();
        s_axis_tvalid <= 1'b0;
        while (coder.pending_nibbles.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Directed samples: extremes, every mode change, saturation and the -127 case
    int directed_samples [N_DIRECTED] = '{
        32767, -32768, -32767, -32764, -32761, -32751, -32748, -32737, -32610, -32736,
        0, -127, -254, -127, 1, -125, -251, -378, -513,
        32767, 32767, 32767, 32767, -32768, -32768
    };
    bit directed_first [N_DIRECTED] = '{
        1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1
    };

    initial begin
        int n;
        int k;
        int kind;
        int seg_len;
        int cur;
        int vel;
        bit restart;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_sample(directed_samples[i][15:0], directed_first[i]);
        end
        wait_for_drain();

        // Random walks keep differences small enough to reach byte and nibble mode
        cur = 0;
        vel = 0;
        n   = 0;
        while (n < RANDOM_ITEMS) begin
            kind    = $urandom_range(0, 9);
            seg_len = $urandom_range(4, 30);
            restart = ($urandom_range(0, 7) == 0);
            if (restart) begin
                cur = int'($urandom_range(0, 400)) - 200;
                vel = 0;
            end
            for (k = 0; k < seg_len && n < RANDOM_ITEMS; k++) begin
                // Fill the block behind a long receiver hold
                if (n == 120) begin
                    rx_hold_len = LONG_HOLD;
                    burst_free  = 24;
                end
                if (n == 260) begin
                    wait_for_drain();
                end
                if (n == RANDOM_ITEMS - 60) begin
                    idle_on = 1'b0;
                end
                if (kind <= 5) begin
                    vel += int'($urandom_range(0, 18)) - 9;
                    if (vel > 300) vel = 300;
                    if (vel < -300) vel = -300;
                end else if (kind <= 7) begin
                    vel = int'($urandom_range(0, 280)) - 140;
                end
                if (kind == 9) begin
                    if ($urandom_range(0, 7) == 0) begin
                        cur = -32768;
                    end else begin
                        cur = int'($urandom_range(0, 65535)) - 32768;
                    end
                end else begin
                    cur += vel;
                    if (cur > 32767) begin
                        cur = 32767;
                        vel = 0;
                    end else if (cur < -32768) begin
                        cur = -32768;
                        vel = 0;
                    end
                end
                send_sample(cur[15:0], restart && (k == 0));
                n++;
            end
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (coder.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/dne_pkg.sv
rtl/dne_encode.sv
rtl/delta_nibble_encoder_top.sv
rtl/dne_checker.sv
verif/tb_delta_nibble_encoder_top.sv
